### src/bounded_list_engine_core_macros.svh
// Assertion macros shared by the bounded list engine RTL.
// Needs no other file; define NO_ASSERTIONS to compile them away.
`ifndef BOUNDED_LIST_ENGINE_CORE_MACROS_SVH
`define BOUNDED_LIST_ENGINE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define BLC_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bounded list engine: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define BLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bounded list engine: next-cycle check failed");
`else
`define BLC_ASSERT_HOLDS(label, clk, rst, ante, cons)
`define BLC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/blc_pkg.sv
// Shared types and constants of the bounded list engine.
// Depends on nothing; every RTL module but blc_ram refers to it by scoped names.
package blc_pkg;

   // List capacity and derived widths.
   localparam int DEPTH = 32;
   localparam int PTR_W = $clog2(DEPTH);
   localparam logic [PTR_W:0] DEPTH_WIDE = (PTR_W + 1)'(DEPTH);

   // Fixed field widths.
   localparam int OPCODE_W = 3;
   localparam int ELEM_W   = 32;
   localparam int INDEX_W  = 5;
   localparam int COUNT_W  = 6;
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

   // Request opcodes.
   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_REMOVE_AT  = 3'd4,
      OP_REVERSE    = 3'd5,
      OP_DUMP       = 3'd6
   } opcode_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // Commands handed from the front end to the executor.
   typedef enum logic [2:0] {
      CMD_PUSH_FRONT,
      CMD_PUSH_BACK,
      CMD_POP_FRONT,
      CMD_POP_BACK,
      CMD_REMOVE_AT,
      CMD_REVERSE,
      CMD_DUMP,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]      opcode;
      logic signed [ELEM_W-1:0] value;
      logic [INDEX_W-1:0]       index;
   } req_word_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] element;
      logic [COUNT_W-1:0]       count;
      status_type               status;
      logic                     last;
   } rsp_word_type;

   typedef struct packed {
      cmd_kind_type             kind;
      logic signed [ELEM_W-1:0] value;
      logic [INDEX_W-1:0]       index;
   } cmd_word_type;

endpackage

### src/bounded_list_engine_core.sv
// Top level of the bounded list engine: an ordered list of up to 32
// signed words. Depends on blc_pkg, blc_front, blc_back and blc_out_queue.
//
// Usage:
// Requests enter through a queue-style port: a word is taken at a rising
// edge with req_push high and req_full low. Results leave the same way:
// the oldest result sits on rsp_word while rsp_empty is low and is taken
// at an edge with rsp_pop high. Every request gives one result word except
// a dump, which gives one word per element, front first, with last set on
// the final one; a dump of an empty list gives a single empty-status word.
// Flow: the front end queues two requests, the executor carries out one
// at a time and takes no new command before its last result is queued.
// Pushes, pops, reverse and no-ops go from S_IDLE to S_REPLY, which queues
// the result word. Removal at index i moves each element behind it one
// place forward, one RAM read and write per moved element. A dump reads
// the front element, then delivers one element per cycle while the result queue has room.
// Reset empties the list and both queues; the RAM is not cleared.
// When the receiver stalls, up to two results wait in the result queue,
// the executor halts, and req_full rises once the request queue fills.
module bounded_list_engine_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  blc_pkg::req_word_type req_word,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output blc_pkg::rsp_word_type rsp_word
);

   logic                  cmd_valid;
   logic                  cmd_take;
   blc_pkg::cmd_word_type cmd_word;
   logic                  out_push;
   logic                  out_full;
   blc_pkg::rsp_word_type out_word;

   // Request intake and classification.
   blc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd_word  (cmd_word)
   );

   // List executor.
   blc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd       (cmd_word),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_word  (out_word)
   );

   // Result queue toward the receiver.
   blc_out_queue u_out (
      .clock     (clock),
      .reset     (reset),
      .in_push   (out_push),
      .in_full   (out_full),
      .in_word   (out_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule

### src/blc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module blc_ram #(
   parameter int WIDTH   = 32,
   parameter int ENTRIES = 32
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [ENTRIES];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read ports; read data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/blc_front.sv
// Front end: accepts request words, classifies the opcode into a command
// and holds commands in a two-word queue. Depends on blc_pkg.
module blc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  blc_pkg::req_word_type req_word,
   output logic                  cmd_valid,
   input  logic                  cmd_take,
   output blc_pkg::cmd_word_type cmd_word
);

   blc_pkg::cmd_word_type slot_ff [2];
   blc_pkg::cmd_word_type new_cmd;
   logic                  wr_ptr_ff;
   logic                  wr_ptr_in;
   logic                  rd_ptr_ff;
   logic                  rd_ptr_in;
   logic [1:0]            fill_ff;
   logic [1:0]            fill_in;
   logic                  do_write;
   logic                  do_read;

   // Decode the opcode; the unused code becomes a no-op.
   always_comb begin
      new_cmd.value = req_word.value;
      new_cmd.index = req_word.index;
      unique case (req_word.opcode)
         blc_pkg::OP_PUSH_FRONT: new_cmd.kind = blc_pkg::CMD_PUSH_FRONT;
         blc_pkg::OP_PUSH_BACK:  new_cmd.kind = blc_pkg::CMD_PUSH_BACK;
         blc_pkg::OP_POP_FRONT:  new_cmd.kind = blc_pkg::CMD_POP_FRONT;
         blc_pkg::OP_POP_BACK:   new_cmd.kind = blc_pkg::CMD_POP_BACK;
         blc_pkg::OP_REMOVE_AT:  new_cmd.kind = blc_pkg::CMD_REMOVE_AT;
         blc_pkg::OP_REVERSE:    new_cmd.kind = blc_pkg::CMD_REVERSE;
         blc_pkg::OP_DUMP:       new_cmd.kind = blc_pkg::CMD_DUMP;
         default:                new_cmd.kind = blc_pkg::CMD_NOP;
      endcase
   end

   // Queue pointers and fill level.
   assign req_full  = (fill_ff == 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign do_write  = req_push && !req_full;
   assign do_read   = cmd_take && cmd_valid;
   assign wr_ptr_in = do_write ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = do_read ? !rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      fill_in = fill_ff;
      if (do_write && !do_read) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_read && !do_write) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Command storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_write) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign cmd_word = slot_ff[rd_ptr_ff];

endmodule

### src/blc_out_queue.sv
// Two-word result queue that parts the executor from the result channel.
// Depends on blc_pkg.
module blc_out_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_push,
   output logic                  in_full,
   input  blc_pkg::rsp_word_type in_word,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output blc_pkg::rsp_word_type rsp_word
);

   blc_pkg::rsp_word_type slot_ff [2];
   logic                  wr_ptr_ff;
   logic                  wr_ptr_in;
   logic                  rd_ptr_ff;
   logic                  rd_ptr_in;
   logic [1:0]            fill_ff;
   logic [1:0]            fill_in;
   logic                  do_write;
   logic                  do_read;

   // Pointer and fill bookkeeping.
   assign in_full   = (fill_ff == 2'd2);
   assign rsp_empty = (fill_ff == 2'd0);
   assign do_write  = in_push && !in_full;
   assign do_read   = rsp_pop && !rsp_empty;
   assign wr_ptr_in = do_write ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = do_read ? !rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      fill_in = fill_ff;
      if (do_write && !do_read) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_read && !do_write) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Result storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_write) begin
         slot_ff[wr_ptr_ff] <= in_word;
      end
   end

   assign rsp_word = slot_ff[rd_ptr_ff];

endmodule

### src/blc_back.sv
// Executor: keeps the list as a ring in a RAM with a head pointer and a
// direction bit, and carries out one command at a time. Depends on blc_pkg,
// blc_ram and the assertion macro header.
`include "bounded_list_engine_core_macros.svh"
module blc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_take,
   input  blc_pkg::cmd_word_type cmd,
   input  logic                  out_full,
   output logic                  out_push,
   output blc_pkg::rsp_word_type out_word
);

   typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_DUMP, S_REPLY} state_type;

   state_type                       state_ff;
   state_type                       state_in;
   logic [blc_pkg::PTR_W-1:0]       head_ff;
   logic [blc_pkg::PTR_W-1:0]       head_in;
   logic                            dir_ff;
   logic                            dir_in;
   logic [blc_pkg::COUNT_W-1:0]     count_ff;
   logic [blc_pkg::COUNT_W-1:0]     count_in;
   logic [blc_pkg::COUNT_W-1:0]     pos_ff;
   logic [blc_pkg::COUNT_W-1:0]     pos_in;
   blc_pkg::status_type             st_ff;
   blc_pkg::status_type             st_in;

   logic                            ram_wr_en;
   logic [blc_pkg::PTR_W-1:0]       ram_wr_addr;
   logic [blc_pkg::ELEM_W-1:0]      ram_wr_data;
   logic                            ram_rd_en;
   logic [blc_pkg::PTR_W-1:0]       ram_rd_addr;
   logic [blc_pkg::ELEM_W-1:0]      ram_rd_data;

   logic                            is_empty;
   logic                            is_full;
   logic [blc_pkg::COUNT_W-1:0]     idx_ext;
   logic [blc_pkg::COUNT_W-1:0]     idx_next;
   logic [blc_pkg::COUNT_W-1:0]     count_dec;
   logic [blc_pkg::COUNT_W-1:0]     pos_next;
   logic [blc_pkg::COUNT_W-1:0]     pos_plus2;

   // Map a position counted from the front to a RAM address.
   function automatic logic [blc_pkg::PTR_W-1:0] phys(
      input logic [blc_pkg::PTR_W-1:0] base,
      input logic                      rev,
      input logic [blc_pkg::PTR_W-1:0] off
   );
      logic [blc_pkg::PTR_W:0] step;
      logic [blc_pkg::PTR_W:0] sum;
      step = rev ? (blc_pkg::DEPTH_WIDE - {1'b0, off}) : {1'b0, off};
      sum  = {1'b0, base} + step;
      if (sum >= blc_pkg::DEPTH_WIDE) begin
         sum = sum - blc_pkg::DEPTH_WIDE;
      end
      return sum[blc_pkg::PTR_W-1:0];
   endfunction

   blc_ram #(
      .WIDTH   (blc_pkg::ELEM_W),
      .ENTRIES (blc_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Helper values shared by the sequencer.
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == blc_pkg::FULL_COUNT);
   assign idx_ext   = blc_pkg::COUNT_W'(cmd.index);
   assign idx_next  = idx_ext + blc_pkg::COUNT_W'(1);
   assign count_dec = count_ff - blc_pkg::COUNT_W'(1);
   assign pos_next  = pos_ff + blc_pkg::COUNT_W'(1);
   assign pos_plus2 = pos_ff + blc_pkg::COUNT_W'(2);

   // Sequencer next-state logic.
   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      dir_in      = dir_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      st_in       = st_ff;
      cmd_take    = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = head_ff;
      ram_wr_data = cmd.value;
      ram_rd_en   = 1'b0;
      ram_rd_addr = head_ff;
      out_push    = 1'b0;
      out_word.element = '0;
      out_word.count   = count_ff;
      out_word.status  = st_ff;
      out_word.last    = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               st_in    = blc_pkg::ST_OK;
               state_in = S_REPLY;
               unique case (cmd.kind)
                  blc_pkg::CMD_PUSH_FRONT: begin
                     if (is_full) begin
                        st_in = blc_pkg::ST_FULL;
                     end else begin
                        head_in     = phys(head_ff, dir_ff, blc_pkg::PTR_W'(blc_pkg::DEPTH - 1));
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = head_in;
                        count_in    = count_ff + blc_pkg::COUNT_W'(1);
                     end
                  end
                  blc_pkg::CMD_PUSH_BACK: begin
                     if (is_full) begin
                        st_in = blc_pkg::ST_FULL;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = phys(head_ff, dir_ff, count_ff[blc_pkg::PTR_W-1:0]);
                        count_in    = count_ff + blc_pkg::COUNT_W'(1);
                     end
                  end
                  blc_pkg::CMD_POP_FRONT: begin
                     if (is_empty) begin
                        st_in = blc_pkg::ST_EMPTY;
                     end else begin
                        head_in  = phys(head_ff, dir_ff, blc_pkg::PTR_W'(1));
                        count_in = count_dec;
                     end
                  end
                  blc_pkg::CMD_POP_BACK: begin
                     if (is_empty) begin
                        st_in = blc_pkg::ST_EMPTY;
                     end else begin
                        count_in = count_dec;
                     end
                  end
                  blc_pkg::CMD_REMOVE_AT: begin
                     if (is_empty) begin
                        st_in = blc_pkg::ST_EMPTY;
                     end else if (idx_ext >= count_ff) begin
                        st_in = blc_pkg::ST_RANGE;
                     end else if (idx_ext == count_dec) begin
                        count_in = count_dec;
                     end else begin
                        // Close the gap: fetch the element just behind it.
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = phys(head_ff, dir_ff, idx_next[blc_pkg::PTR_W-1:0]);
                        pos_in      = idx_ext;
                        state_in    = S_SHIFT;
                     end
                  end
                  blc_pkg::CMD_REVERSE: begin
                     if (count_ff > blc_pkg::COUNT_W'(1)) begin
                        head_in = phys(head_ff, dir_ff, count_dec[blc_pkg::PTR_W-1:0]);
                        dir_in  = !dir_ff;
                     end
                  end
                  blc_pkg::CMD_DUMP: begin
                     if (is_empty) begin
                        st_in = blc_pkg::ST_EMPTY;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = head_ff;
                        pos_in      = '0;
                        state_in    = S_DUMP;
                     end
                  end
                  blc_pkg::CMD_NOP: begin
                     st_in = blc_pkg::ST_OK;
                  end
                  default: begin
                     st_in = blc_pkg::ST_OK;
                  end
               endcase
            end
         end
         S_SHIFT: begin
            // Move the fetched element one place toward the front.
            ram_wr_en   = 1'b1;
            ram_wr_addr = phys(head_ff, dir_ff, pos_ff[blc_pkg::PTR_W-1:0]);
            ram_wr_data = ram_rd_data;
            if (pos_plus2 < count_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = phys(head_ff, dir_ff, pos_plus2[blc_pkg::PTR_W-1:0]);
               pos_in      = pos_next;
            end else begin
               count_in = count_dec;
               st_in    = blc_pkg::ST_OK;
               state_in = S_REPLY;
            end
         end
         S_DUMP: begin
            // One element per cycle while the result queue has room.
            out_word.element = signed'(ram_rd_data);
            out_word.status  = blc_pkg::ST_OK;
            out_word.last    = (pos_next == count_ff);
            if (!out_full) begin
               out_push = 1'b1;
               if (pos_next == count_ff) begin
                  state_in = S_IDLE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = phys(head_ff, dir_ff, pos_next[blc_pkg::PTR_W-1:0]);
                  pos_in      = pos_next;
               end
            end
         end
         S_REPLY: begin
            if (!out_full) begin
               out_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and list bookkeeping registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         dir_ff   <= 1'b0;
         count_ff <= '0;
         pos_ff   <= '0;
         st_ff    <= blc_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         dir_ff   <= dir_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         st_ff    <= st_in;
      end
   end

   // Checks on the executor.
   `BLC_ASSERT_HOLDS(count_bounded, clock, reset, 1'b1, count_ff <= blc_pkg::FULL_COUNT)
   `BLC_ASSERT_HOLDS(push_has_room, clock, reset, out_push, !out_full)
   `BLC_ASSERT_NEXT(push_back_grows, clock, reset, state_ff == S_IDLE && cmd_valid && cmd.kind == blc_pkg::CMD_PUSH_BACK && !is_full, count_ff == $past(count_ff) + 1'b1)
   `BLC_ASSERT_NEXT(dump_walk_advances, clock, reset, state_ff == S_DUMP && out_push && !out_word.last, state_ff == S_DUMP && pos_ff == $past(pos_ff) + 1'b1)

endmodule

### verif/bounded_list_engine_core_tb.sv
// Self-checking testbench for bounded_list_engine_core: a list model predicts
// every result word. Depends on blc_pkg and the RTL of the engine.
`timescale 1ns / 100ps

module bounded_list_engine_core_tb;

   // The opcode value that the package leaves without a name.
   localparam logic [blc_pkg::OPCODE_W-1:0] OP_UNUSED = 3'd7;
   localparam int RESET_CYCLES = 11;
   localparam int DRAIN_CYCLES = 60;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int HOLD_AFTER_WORDS = 40;
   localparam int CALM_WORDS = 50;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SHOWN_MISMATCHES = 10;

   typedef struct {
      blc_pkg::req_word_type word;
      bit                    wait_idle;
   } queued_request_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   blc_pkg::req_word_type req_word = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   blc_pkg::rsp_word_type rsp_word;

   // Stimulus and scoreboard state.
   queued_request_type request_backlog[$];
   blc_pkg::rsp_word_type list_results_due[$];
   logic signed [blc_pkg::ELEM_W-1:0] list_mem[$];
   int list_len = 0;
   int gen_len = 0;
   int total_requests = 0;
   int accepted_total = 0;
   int due_total = 0;
   int seen_total = 0;
   int fail_count = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int cycle_count = 0;
   logic calm;
   logic long_hold;

   assign calm = (accepted_total + CALM_WORDS >= total_requests);
   assign long_hold = (hold_left != 0);

   bounded_list_engine_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // List model: applies one request and queues the result words it causes.
   function automatic void apply_list_request(blc_pkg::req_word_type w);
      blc_pkg::rsp_word_type r;
      logic signed [blc_pkg::ELEM_W-1:0] swap;
      r = '0;
      r.status = blc_pkg::ST_OK;
      r.last = 1'b1;
      list_len = list_mem.size();
      case (w.opcode)
         blc_pkg::OP_PUSH_FRONT: begin
            if (list_len >= blc_pkg::DEPTH) r.status = blc_pkg::ST_FULL;
            else list_mem.push_front(w.value);
         end
         blc_pkg::OP_PUSH_BACK: begin
            if (list_len >= blc_pkg::DEPTH) r.status = blc_pkg::ST_FULL;
            else list_mem.push_back(w.value);
         end
         blc_pkg::OP_POP_FRONT: begin
            if (list_len == 0) r.status = blc_pkg::ST_EMPTY;
            else list_mem.delete(0);
         end
         blc_pkg::OP_REMOVE_AT: begin
            if (list_len == 0) begin
               r.status = blc_pkg::ST_EMPTY;
            end else if (int'(w.index) >= list_len) begin
               r.status = blc_pkg::ST_RANGE;
            end else begin
               list_mem.delete(int'(w.index));
            end
         end
         blc_pkg::OP_POP_BACK: begin
            if (list_len == 0) r.status = blc_pkg::ST_EMPTY;
            else list_mem.delete(list_len - 1);
         end
         blc_pkg::OP_REVERSE: begin
            for (int i = 0; i < list_len / 2; i++) begin
               swap = list_mem[i];
               list_mem[i] = list_mem[list_len-1-i];
               list_mem[list_len-1-i] = swap;
            end
         end
         default: ;
      endcase
      list_len = list_mem.size();
      r.count = blc_pkg::COUNT_W'(list_len);
      // A dump of a non-empty list yields one word per element, front first.
      if (w.opcode == blc_pkg::OP_DUMP && list_len > 0) begin
         for (int i = 0; i < list_len; i++) begin
            r.element = list_mem[i];
            r.last = (i == list_len - 1);
            list_results_due.push_back(r);
            due_total++;
         end
      end else begin
         if (w.opcode == blc_pkg::OP_DUMP) r.status = blc_pkg::ST_EMPTY;
         list_results_due.push_back(r);
         due_total++;
      end
   endfunction

   // Queues one request and tracks the list length it leaves behind.
   task automatic queue_request(logic [blc_pkg::OPCODE_W-1:0] op,
                                logic signed [blc_pkg::ELEM_W-1:0] val,
                                logic [blc_pkg::INDEX_W-1:0] idx, bit wait_idle = 1'b0);
      queued_request_type q;
      q.word.opcode = op;
      q.word.value = val;
      q.word.index = idx;
      q.wait_idle = wait_idle;
      request_backlog.push_back(q);
      case (op)
         blc_pkg::OP_PUSH_FRONT, blc_pkg::OP_PUSH_BACK:
            if (gen_len < blc_pkg::DEPTH) gen_len++;
         blc_pkg::OP_POP_FRONT, blc_pkg::OP_POP_BACK: if (gen_len > 0) gen_len--;
         blc_pkg::OP_REMOVE_AT: if (int'(idx) < gen_len) gen_len--;
         default: ;
      endcase
   endtask

   function automatic logic signed [blc_pkg::ELEM_W-1:0] random_value();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [blc_pkg::INDEX_W-1:0] random_index();
      return blc_pkg::INDEX_W'($urandom_range(0, 31));
   endfunction

   // Random request; the push share steers the list toward full or empty.
   task automatic queue_random_request(int push_pct, bit wait_idle = 1'b0);
      logic [blc_pkg::OPCODE_W-1:0] op;
      logic [blc_pkg::INDEX_W-1:0]  idx;
      int pick;
      if (gen_len > 0 && $urandom_range(0, 3) != 0)
         idx = blc_pkg::INDEX_W'($urandom_range(0, gen_len - 1));
      else idx = random_index();
      if ($urandom_range(0, 99) < push_pct) begin
         op = $urandom_range(0, 1) ? blc_pkg::OP_PUSH_FRONT : blc_pkg::OP_PUSH_BACK;
      end else begin
         pick = $urandom_range(0, 15);
         if (pick < 3) op = blc_pkg::OP_POP_FRONT;
         else if (pick < 6) op = blc_pkg::OP_POP_BACK;
         else if (pick < 11) op = blc_pkg::OP_REMOVE_AT;
         else if (pick < 13) op = blc_pkg::OP_REVERSE;
         else if (pick < 15) op = blc_pkg::OP_DUMP;
         else op = OP_UNUSED;
      end
      queue_request(op, random_value(), idx, wait_idle);
   endtask

   // Result check against the oldest expected word.
   function automatic void check_result(blc_pkg::rsp_word_type got);
      blc_pkg::rsp_word_type want;
      if (list_results_due.size() == 0) begin
         fail_count++;
         if (fail_count <= SHOWN_MISMATCHES)
            $display("ERROR: unexpected result word element=%0d count=%0d %s%0d last=%0d",
                     got.element, got.count, "status=", got.status, got.last);
      end else begin
         want = list_results_due.pop_front();
         if (got.element !== want.element || got.count !== want.count ||
             got.status !== want.status || got.last !== want.last) begin
            fail_count++;
            if (fail_count <= SHOWN_MISMATCHES) begin
               $display("ERROR: word %0d expected element=%0d count=%0d status=%0d last=%0d,",
                        seen_total, want.element, want.count, want.status, want.last);
               $display("       got element=%0d count=%0d status=%0d last=%0d",
                        got.element, got.count, got.status, got.last);
            end
         end
      end
   endfunction

   // Request driver: offers queued requests with random idle bursts.
   always @(posedge clock) begin
      logic                  next_push;
      blc_pkg::req_word_type next_word;
      queued_request_type    q;
      next_push = req_push;
      next_word = req_word;
      if (!reset) begin
         if (req_push && !req_full) begin
            apply_list_request(req_word);
            accepted_total <= accepted_total + 1;
            next_push = 1'b0;
         end
         if (!next_push) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (request_backlog.size() != 0) begin
               if (request_backlog[0].wait_idle && seen_total != due_total) begin
                  // Hold back until every outstanding result word has come out.
               end else if (!calm && $urandom_range(0, 11) == 0) begin
                  send_gap = $urandom_range(1, 18) - 1;
               end else begin
                  q = request_backlog.pop_front();
                  next_push = 1'b1;
                  next_word = q.word;
               end
            end
         end
         req_push <= next_push;
         req_word <= next_word;
      end
   end

   // Result monitor: checks each accepted word and pops with random stalls.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (list_results_due.size() != 0) seen_total <= seen_total + 1;
            check_result(rsp_word);
         end
         if (long_hold) begin
            rsp_pop <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_pop <= 1'b0;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            recv_gap = $urandom_range(1, 18) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // One long receiver hold-off so that both queues fill and req_full rises.
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end else if (!hold_done && accepted_total >= HOLD_AFTER_WORDS) begin
            hold_left <= LONG_HOLD_CYCLES;
            hold_done <= 1'b1;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int random_done;
      int seg_left;
      int push_pct;

      // Directed part: empty-list cases, one-element cases, extremes, all opcodes.
      queue_request(blc_pkg::OP_DUMP, 0, 5'd0);
      queue_request(blc_pkg::OP_POP_FRONT, 0, 5'd0);
      queue_request(blc_pkg::OP_POP_BACK, 0, 5'd0);
      queue_request(blc_pkg::OP_REMOVE_AT, 0, 5'd0);
      queue_request(blc_pkg::OP_REVERSE, 0, 5'd0);
      queue_request(blc_pkg::OP_PUSH_BACK, 32'sh7FFF_FFFF, 5'd0);
      queue_request(blc_pkg::OP_REVERSE, 0, 5'd0);
      queue_request(blc_pkg::OP_REMOVE_AT, 0, 5'd1);
      queue_request(blc_pkg::OP_REMOVE_AT, 0, 5'd0);
      queue_request(blc_pkg::OP_PUSH_FRONT, 32'sh8000_0000, 5'd31);
      queue_request(blc_pkg::OP_PUSH_BACK, -1, 5'd0);
      queue_request(blc_pkg::OP_PUSH_BACK, 0, 5'd0);
      queue_request(blc_pkg::OP_PUSH_FRONT, 1, 5'd0);
      queue_request(blc_pkg::OP_DUMP, 0, 5'd0);
      queue_request(blc_pkg::OP_REVERSE, 0, 5'd0);
      queue_request(blc_pkg::OP_DUMP, 0, 5'd0);
      queue_request(blc_pkg::OP_REMOVE_AT, 0, 5'd31);
      queue_request(blc_pkg::OP_REMOVE_AT, 0, 5'd3);
      queue_request(blc_pkg::OP_REMOVE_AT, 0, 5'd1);
      queue_request(OP_UNUSED, 32'sh7FFF_FFFF, 5'd31);
      queue_request(blc_pkg::OP_POP_FRONT, 0, 5'd0);
      queue_request(blc_pkg::OP_POP_BACK, 0, 5'd0);
      queue_request(blc_pkg::OP_DUMP, 0, 5'd0);

      // Fill to capacity, overflow, then walk a full list.
      queue_request(blc_pkg::OP_PUSH_BACK, random_value(), random_index(), 1'b1);
      while (gen_len < blc_pkg::DEPTH)
         queue_request($urandom_range(0, 1) ? blc_pkg::OP_PUSH_FRONT : blc_pkg::OP_PUSH_BACK,
                       random_value(), random_index());
      queue_request(blc_pkg::OP_PUSH_FRONT, random_value(), 5'd0);
      queue_request(blc_pkg::OP_PUSH_BACK, random_value(), 5'd0);
      queue_request(blc_pkg::OP_DUMP, 0, 5'd0);
      queue_request(blc_pkg::OP_REMOVE_AT, 0, 5'd31);
      queue_request(blc_pkg::OP_REMOVE_AT, 0, 5'd30);
      queue_request(blc_pkg::OP_REMOVE_AT, 0, 5'd0);
      queue_request(blc_pkg::OP_REVERSE, 0, 5'd0);
      queue_request(blc_pkg::OP_DUMP, 0, 5'd0);

      // Random part in segments that grow, shrink or hold the list length.
      random_done = 0;
      seg_left = 0;
      push_pct = 45;
      while (random_done < 310) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(15, 40);
            case ($urandom_range(0, 2))
               0: push_pct = 75;
               1: push_pct = 20;
               default: push_pct = 45;
            endcase
         end
         queue_random_request(push_pct, random_done == 150);
         seg_left--;
         random_done++;
      end
      total_requests = request_backlog.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Let all requests go in and all result words come out.
      while (accepted_total != total_requests) @(posedge clock);
      while (seen_total != due_total) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && list_results_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
